/* hw/rtl/dff_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duplicate frame filter package
// Shared types, widths, register indexes and verdict codes.
// ----------------------------------------------------------------------------
package dff_pkg;

  localparam int ADDR_W      = 16;
  localparam int SEQ_W       = 8;
  localparam int LEN_W       = 7;
  localparam int CFG_INDEX_W = 8;
  localparam int VERDICT_W   = 3;

  // Default number of (sender, sequence) pairs kept in the history.
  localparam int HISTORY_DEPTH_DEF = 16;

  // Frame length that marks an acknowledgement.
  localparam logic [LEN_W-1:0] ACK_FRAME_LENGTH = 7'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDRESS      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BROADCAST_ADDRESS = 8'd1;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_DELIVER   = 3'd0,
    VERDICT_ACK       = 3'd1,
    VERDICT_PARSE     = 3'd2,
    VERDICT_NOT_US    = 3'd3,
    VERDICT_DUPLICATE = 3'd4
  } verdict_t;

  // One history entry, also used as the lookup key.
  typedef struct packed {
    logic [ADDR_W-1:0] sender;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

endpackage

/* hw/rtl/duplicate_frame_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duplicate frame filter
// Receive-side frame classifier of a radio MAC with a sequence-number
// duplicate history built as a shifting row of cells.
// ----------------------------------------------------------------------------
// Each accepted item is the header summary of one received frame, and each
// produces exactly one verdict item. The checks are applied in order: a frame
// whose length equals the acknowledgement length is ignored, a frame that
// failed to parse is rejected, and a frame whose receiver is neither the node
// address nor the broadcast address is rejected as not for us. A frame that
// survives those checks is compared with every (sender, sequence) pair in the
// history; a match drops it as a duplicate, otherwise the history shifts by
// one cell (the oldest pair falls off the end), the new pair enters the first
// cell and the frame is delivered. The history holds zeros after reset, so a
// frame from sender zero with sequence zero counts as a duplicate until those
// entries have been pushed out. After acceptance every cell registers its
// compare, then the compares are combined and the verdict is decided and
// registered. The input is stalled from the capture until the decision has
// been made, so a new frame is not accepted before the previous decision;
// a verdict that is held up downstream also holds up the decision. The
// verdict register lets the next frame be taken while the previous verdict
// still waits downstream. The configuration port is always ready; writes to
// indexes other than the two address registers are ignored.
// ----------------------------------------------------------------------------
module duplicate_frame_filter #(
  parameter int HISTORY_DEPTH = dff_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,

  // Frame header channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dff_pkg::LEN_W-1:0]          frame_length,
  input  logic                               parse_ok,
  input  logic [dff_pkg::ADDR_W-1:0]         receiver_address,
  input  logic [dff_pkg::ADDR_W-1:0]         sender_address,
  input  logic [dff_pkg::SEQ_W-1:0]          sequence_number,

  // Verdict channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dff_pkg::VERDICT_W-1:0]      verdict,

  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dff_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dff_pkg::ADDR_W-1:0]         cfg_data
);

  // One-hot sequencer states.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_MATCH  = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t                      state;
  state_t                      state_next;

  logic [dff_pkg::ADDR_W-1:0]  node_address;
  logic [dff_pkg::ADDR_W-1:0]  broadcast_address;

  // Captured frame: the lookup key plus the outcome of the header checks.
  dff_pkg::entry_t             key;
  dff_pkg::verdict_t           pre_verdict;
  logic                        need_lookup;

  dff_pkg::verdict_t           result;
  dff_pkg::verdict_t           result_next;

  dff_pkg::entry_t             chain [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0]    match_vec;

  logic                        in_accept;
  logic                        out_free;
  logic                        hit;
  logic                        shift_en;
  logic                        load_result;
  dff_pkg::verdict_t           check_verdict;
  logic                        check_pass;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign verdict   = result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_address      <= '0;
      broadcast_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == dff_pkg::REG_NODE_ADDRESS) begin
        node_address <= cfg_data;
      end else if (cfg_index == dff_pkg::REG_BROADCAST_ADDRESS) begin
        broadcast_address <= cfg_data;
      end
    end
  end

  // Header checks in their fixed order of precedence.
  always_comb begin
    check_verdict = dff_pkg::VERDICT_DELIVER;
    check_pass    = 1'b0;
    priority if (frame_length == dff_pkg::ACK_FRAME_LENGTH) begin
      check_verdict = dff_pkg::VERDICT_ACK;
    end else if (!parse_ok) begin
      check_verdict = dff_pkg::VERDICT_PARSE;
    end else if (receiver_address != node_address &&
                 receiver_address != broadcast_address) begin
      check_verdict = dff_pkg::VERDICT_NOT_US;
    end else begin
      check_pass = 1'b1;
    end
  end

  // Frame capture; the key stays put while the cells compare against it.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      key.sender  <= sender_address;
      key.seq     <= sequence_number;
      pre_verdict <= check_verdict;
      need_lookup <= check_pass;
    end
  end

  // The history row. Cell 0 takes the new pair, every other cell takes its
  // neighbour's pair when the row shifts.
  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
    dff_pkg::entry_t prev;
    if (k == 0) begin : g_head
      assign prev = key;
    end else begin : g_body
      assign prev = chain[k-1];
    end
    dff_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (shift_en),
      .key      (key),
      .prev     (prev),
      .entry    (chain[k]),
      .match    (match_vec[k])
    );
  end

  // Decision: the registered compares are combined and the verdict chosen.
  assign hit         = |match_vec;
  assign out_free    = !out_valid || !out_stall;
  assign load_result = (state == S_DECIDE) && out_free;
  assign shift_en    = load_result && need_lookup && !hit;

  always_comb begin
    if (!need_lookup) begin
      result_next = pre_verdict;
    end else if (hit) begin
      result_next = dff_pkg::VERDICT_DUPLICATE;
    end else begin
      result_next = dff_pkg::VERDICT_DELIVER;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Verdict register, held until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // A delivered frame leaves its own pair at the head of the history.
  a_deliver_enters_head: assert property (@(posedge clk) disable iff (rst)
    (load_result && result_next == dff_pkg::VERDICT_DELIVER) |=>
      (chain[0] == $past(key)))
    else $error("delivered pair missing from the history head");

  // A rejected frame leaves the history untouched.
  a_reject_keeps_history: assert property (@(posedge clk) disable iff (rst)
    (load_result && result_next != dff_pkg::VERDICT_DELIVER) |=>
      $stable(chain[0]))
    else $error("history changed on a rejected frame");

  // A new verdict only ever appears out of the decision step.
  a_verdict_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DECIDE))
    else $error("verdict raised outside the decision step");

  // An accepted frame always moves on to the compare step.
  a_accept_to_match: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_MATCH))
    else $error("accepted frame did not start a compare");
`endif

endmodule

/* hw/rtl/dff_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duplicate frame filter history cell
// Holds one (sender, sequence) pair, compares it with the broadcast key and
// passes its pair on to the next cell when the history shifts.
// ----------------------------------------------------------------------------
module dff_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift_en,
  input  dff_pkg::entry_t key,
  input  dff_pkg::entry_t prev,
  output dff_pkg::entry_t entry,
  output logic            match
);

  // The history resets to zeros, so a zero pair matches until overwritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (shift_en) begin
      entry <= prev;
    end
  end

  always_ff @(posedge clk) begin
    match <= (entry == key);
  end

endmodule
